/* src/strm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sparse table range-minimum package
// Shared sizes, codes and the queue item type of the range-minimum engine.
// ----------------------------------------------------------------------------
package strm_pkg;

    localparam int MAX_LEN   = 1024;
    localparam int LEVELS    = 11;
    localparam int VAL_W     = 32;
    localparam int POS_W     = $clog2(MAX_LEN);
    localparam int CNT_W     = $clog2(MAX_LEN + 1);
    localparam int LVL_W     = $clog2(LEVELS + 1);
    localparam int TBL_DEPTH = LEVELS * MAX_LEN;
    localparam int TBL_AW    = $clog2(TBL_DEPTH);
    localparam int Q_DEPTH   = 2;

    localparam logic [1:0] KIND_APPEND = 2'd0;
    localparam logic [1:0] KIND_QUERY  = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    typedef enum logic [1:0] {
        OP_APPEND,
        OP_QUERY,
        OP_CLEAR
    } op_t;

    typedef struct packed {
        op_t                      op;
        logic signed [VAL_W-1:0]  value;
        logic [CNT_W-1:0]         range_end;
        logic                     bad_order;
        logic [LVL_W-1:0]         level;
        logic [POS_W-1:0]         pos_x;
        logic [POS_W-1:0]         pos_y;
    } op_item_t;

    function automatic logic [TBL_AW-1:0] tbl_addr(input logic [LVL_W-1:0] lvl,
                                                  input logic [POS_W-1:0] pos);
        logic [LVL_W+POS_W-1:0] full;
        full = {lvl, pos};
        return full[TBL_AW-1:0];
    endfunction

endpackage

/* src/strm_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module strm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* src/strm_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Range-minimum front end
// Accepts input beats, drops unused kinds, and works out the query level
// and the two window positions before the item enters the queue.
// ----------------------------------------------------------------------------
module strm_front import strm_pkg::*; (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [1:0]              kind,
    input  logic signed [VAL_W-1:0] value,
    input  logic [POS_W-1:0]        range_start,
    input  logic [CNT_W-1:0]        range_end,
    output logic                    push,
    output op_item_t                push_item,
    input  logic                    push_ready
);

    logic       hold_valid_reg;
    logic       hold_valid_next;
    op_item_t   hold_item_reg;
    op_item_t   item_next;
    logic [CNT_W-1:0] len;
    logic [LVL_W-1:0] lvl;
    logic [CNT_W:0]   span;

    assign in_ready  = !hold_valid_reg || push_ready;
    assign push      = hold_valid_reg;
    assign push_item = hold_item_reg;

    always_comb
    begin
        len = range_end - CNT_W'(range_start);
        lvl = '0;
        for (int i = 0; i < CNT_W; i++)
        begin
            if (len[i])
            begin
                lvl = LVL_W'(i);
            end
        end
        span = (CNT_W+1)'(1) << lvl;
        item_next.value     = value;
        item_next.range_end = range_end;
        item_next.bad_order = ({1'b0, range_start} >= range_end);
        item_next.level     = lvl;
        item_next.pos_x     = POS_W'(CNT_W'(range_start) + span[CNT_W-1:0] - CNT_W'(1));
        item_next.pos_y     = POS_W'(range_end - CNT_W'(1));
        unique case (kind)
            KIND_APPEND: item_next.op = OP_APPEND;
            KIND_QUERY:  item_next.op = OP_QUERY;
            default:     item_next.op = OP_CLEAR;
        endcase
    end

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (push && push_ready)
        begin
            hold_valid_next = 1'b0;
        end
        if (in_valid && in_ready && kind != KIND_UNUSED)
        begin
            hold_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            hold_item_reg <= item_next;
        end
    end

endmodule

/* src/strm_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Range-minimum item queue
// Short FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module strm_queue import strm_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  op_item_t push_item,
    output logic     push_ready,
    input  logic     pop,
    output op_item_t pop_item,
    output logic     pop_valid
);

    localparam int PW = $clog2(Q_DEPTH);

    op_item_t          entry_reg [Q_DEPTH];
    logic [PW-1:0]     wr_ptr_reg;
    logic [PW-1:0]     rd_ptr_reg;
    logic [PW:0]       fill_reg;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (fill_reg != (PW+1)'(Q_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            fill_reg <= fill_reg + (PW+1)'(do_push) - (PW+1)'(do_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

/* src/strm_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Range-minimum back end
// Runs appends level by level and queries through the value and table
// memories, and holds the result beat in an output register.
// ----------------------------------------------------------------------------
module strm_back import strm_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pop_valid,
    input  op_item_t         pop_item,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [POS_W-1:0] min_position,
    output logic [1:0]       status
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_A_START,
        S_A_LVL,
        S_A_RDV,
        S_A_CMP,
        S_Q_RX,
        S_Q_RY,
        S_Q_VX,
        S_Q_VY,
        S_OUT
    } state_t;

    state_t                  state_reg;
    logic [CNT_W-1:0]        count_reg;
    op_item_t                item_reg;
    logic [LVL_W-1:0]        k_reg;
    logic [POS_W-1:0]        cur_pos_reg;
    logic signed [VAL_W-1:0] cur_val_reg;
    logic [POS_W-1:0]        x_pos_reg;
    logic [POS_W-1:0]        y_pos_reg;
    logic [POS_W-1:0]        res_pos_reg;
    logic [1:0]              res_status_reg;
    logic                    out_valid_reg;
    logic [POS_W-1:0]        out_pos_reg;
    logic [1:0]              out_status_reg;

    logic                    val_we;
    logic [POS_W-1:0]        val_raddr;
    logic [VAL_W-1:0]        val_rdata;
    logic                    tbl_we;
    logic [TBL_AW-1:0]       tbl_waddr;
    logic [POS_W-1:0]        tbl_wdata;
    logic [TBL_AW-1:0]       tbl_raddr;
    logic [POS_W-1:0]        tbl_rdata;

    logic [POS_W-1:0]        p;
    logic [CNT_W:0]          lvl_span;
    logic                    lvl_ok;
    logic [POS_W-1:0]        half;
    logic                    x_wins;

    assign out_valid    = out_valid_reg;
    assign min_position = out_pos_reg;
    assign status       = out_status_reg;
    assign pop          = (state_reg == S_IDLE) && pop_valid;
    assign p            = POS_W'(count_reg);

    assign lvl_span = (CNT_W+1)'(1) << k_reg;
    assign lvl_ok   = (k_reg != LVL_W'(LEVELS))
                   && (lvl_span <= (CNT_W+1)'(count_reg) + (CNT_W+1)'(1));
    assign half     = POS_W'(lvl_span >> 1);
    assign x_wins   = ($signed(val_rdata) <= cur_val_reg);

    strm_ram #(.WIDTH(VAL_W), .DEPTH(MAX_LEN)) u_val_ram (
        .clk   (clk),
        .we    (val_we),
        .waddr (p),
        .wdata (item_reg.value),
        .raddr (val_raddr),
        .rdata (val_rdata)
    );

    strm_ram #(.WIDTH(POS_W), .DEPTH(TBL_DEPTH)) u_tbl_ram (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    always_comb
    begin
        val_we    = (state_reg == S_A_START);
        tbl_we    = 1'b0;
        tbl_waddr = tbl_addr('0, p);
        tbl_wdata = p;
        tbl_raddr = tbl_addr(item_reg.level, item_reg.pos_x);
        val_raddr = tbl_rdata;
        unique case (state_reg)
            S_A_START:
            begin
                tbl_we = 1'b1;
            end
            S_A_LVL:
            begin
                tbl_raddr = tbl_addr(k_reg - LVL_W'(1), p - half);
            end
            S_A_CMP:
            begin
                tbl_we    = 1'b1;
                tbl_waddr = tbl_addr(k_reg, p);
                tbl_wdata = x_wins ? x_pos_reg : cur_pos_reg;
            end
            S_Q_RY:
            begin
                tbl_raddr = tbl_addr(item_reg.level, item_reg.pos_y);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready && state_reg != S_OUT)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (pop_valid)
                    begin
                        item_reg       <= pop_item;
                        res_pos_reg    <= '0;
                        res_status_reg <= ST_OK;
                        unique case (pop_item.op)
                            OP_APPEND:
                            begin
                                if (count_reg == CNT_W'(MAX_LEN))
                                begin
                                    res_status_reg <= ST_FULL;
                                    state_reg      <= S_OUT;
                                end
                                else
                                begin
                                    state_reg <= S_A_START;
                                end
                            end
                            OP_QUERY:
                            begin
                                if (pop_item.bad_order || pop_item.range_end > count_reg)
                                begin
                                    res_status_reg <= ST_BAD_RANGE;
                                    state_reg      <= S_OUT;
                                end
                                else
                                begin
                                    state_reg <= S_Q_RX;
                                end
                            end
                            default:
                            begin
                                count_reg <= '0;
                                state_reg <= S_OUT;
                            end
                        endcase
                    end
                end
                S_A_START:
                begin
                    cur_pos_reg <= p;
                    cur_val_reg <= item_reg.value;
                    k_reg       <= LVL_W'(1);
                    state_reg   <= S_A_LVL;
                end
                S_A_LVL:
                begin
                    if (lvl_ok)
                    begin
                        state_reg <= S_A_RDV;
                    end
                    else
                    begin
                        count_reg <= count_reg + CNT_W'(1);
                        state_reg <= S_OUT;
                    end
                end
                S_A_RDV:
                begin
                    x_pos_reg <= tbl_rdata;
                    state_reg <= S_A_CMP;
                end
                S_A_CMP:
                begin
                    if (x_wins)
                    begin
                        cur_pos_reg <= x_pos_reg;
                        cur_val_reg <= $signed(val_rdata);
                    end
                    k_reg     <= k_reg + LVL_W'(1);
                    state_reg <= S_A_LVL;
                end
                S_Q_RX:
                begin
                    state_reg <= S_Q_RY;
                end
                S_Q_RY:
                begin
                    x_pos_reg <= tbl_rdata;
                    state_reg <= S_Q_VX;
                end
                S_Q_VX:
                begin
                    y_pos_reg   <= tbl_rdata;
                    cur_val_reg <= $signed(val_rdata);
                    state_reg   <= S_Q_VY;
                end
                S_Q_VY:
                begin
                    res_pos_reg <= (cur_val_reg <= $signed(val_rdata)) ? x_pos_reg
                                                                       : y_pos_reg;
                    state_reg   <= S_OUT;
                end
                S_OUT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_pos_reg    <= res_pos_reg;
                        out_status_reg <= res_status_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_LEN))
        else $error("element count above capacity");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (state_reg != S_IDLE))
        else $error("popped item did not start work");

    a_tbl_level: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_A_CMP) |-> (k_reg < LVL_W'(LEVELS)))
        else $error("table write past last level");

    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && (!out_valid_reg || out_ready)) |=> out_valid_reg)
        else $error("finished result not presented");

endmodule

/* src/sparse_table_range_min_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sparse table range-minimum engine
// Appends signed values into an incrementally built sparse table and answers
// leftmost-minimum queries over half-open position ranges.
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  input     in_valid/in_ready    kind, value, range_start, range_end
//  output    out_valid/out_ready  min_position, status
//
// An append builds table levels k = 1 to floor(log2(count + 1)), capped at 10;
// each level is one table read, one value read and one table write on the
// table memory's separate read and write ports.
// A query makes two table reads, two value reads and one compare;
// a clear or a rejected item goes straight to the output state.
// Reset empties the array; the memories need no clearing pass.
// The front end keeps taking beats into a two-entry queue while the back end
// works or while a result beat waits in the output register.
module sparse_table_range_min_top import strm_pkg::*; (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [1:0]              kind,
    input  logic signed [VAL_W-1:0] value,
    input  logic [POS_W-1:0]        range_start,
    input  logic [CNT_W-1:0]        range_end,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [POS_W-1:0]        min_position,
    output logic [1:0]              status
);

    // Front to queue.
    logic     push;
    logic     push_ready;
    op_item_t push_item;

    // Queue to back.
    logic     pop;
    logic     pop_valid;
    op_item_t pop_item;

    strm_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .value       (value),
        .range_start (range_start),
        .range_end   (range_end),
        .push        (push),
        .push_item   (push_item),
        .push_ready  (push_ready)
    );

    strm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .push_ready (push_ready),
        .pop        (pop),
        .pop_item   (pop_item),
        .pop_valid  (pop_valid)
    );

    // The back end owns the element count and both memories.
    strm_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .pop_valid    (pop_valid),
        .pop_item     (pop_item),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .min_position (min_position),
        .status       (status)
    );

endmodule
